/* sv/nnlu_pkg.sv */
package nnlu_pkg;

	// one 24-bit pixel, blue in the lowest byte
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_PIXEL  = 2'd1,
		ST_PAD    = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_SCALE_FACTOR = 1'b0,
		CFG_SOURCE_WIDTH = 1'b1
	} cfg_index_t;

	// field widths
	localparam int unsigned SCALE_W = 7;
	localparam int unsigned WIDTH_W = 11;

endpackage

/* sv/nearest_neighbor_line_upscaler.sv */
// Whole-factor nearest-neighbor upscaler for 24-bit pixel scanlines. Push beats (tuser 0)
// fill a line buffer of up to MAX_SOURCE_WIDTH pixels; once source_width pixels are in,
// pull beats (tuser 1) return the scaled line, each pixel repeated scale_factor times and
// padded with zero bytes to a multiple of four bytes, scale_factor times over, after which
// the block goes back to filling. Every input beat gives exactly one result beat, and a
// beat in the wrong phase is answered with a reject status and changes nothing. One beat
// is taken per clock unless the result stream holds it back; a result passes through the
// registered read port of the line buffer and then the output register. Write the
// configuration only while no beat is in flight; a write in the middle of a line applies
// from the next beat on.
module nearest_neighbor_line_upscaler
	import nnlu_pkg::*;
#(
	parameter int unsigned MAX_SOURCE_WIDTH = 1024,
	parameter int unsigned MAX_SCALE        = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [10:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // in_blue, in_green, in_red
	input  logic [0:0]  s_axis_tuser,  // mode
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_blue, out_green, out_red
	output logic        m_axis_tlast,  // line_end
	output logic [2:0]  m_axis_tuser   // status, group_end
);

	// the width register never exceeds 2047, so no deeper buffer is ever addressed
	localparam int unsigned DEPTH = (MAX_SOURCE_WIDTH < 2047) ? MAX_SOURCE_WIDTH : 2047;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [11:0] DEPTH_L = 12'(DEPTH);
	localparam logic [16:0] MAX_W   = 17'(MAX_SOURCE_WIDTH);
	localparam logic [7:0]  MAX_F   = 8'(MAX_SCALE);

	// configuration registers
	logic [SCALE_W-1:0] scale_factor_q;
	logic [WIDTH_W-1:0] source_width_q;

	// sequencing state
	logic [WIDTH_W-1:0] fill_q, fill_d;
	logic               emit_q, emit_d;
	logic [WIDTH_W-1:0] col_q, col_d;
	logic [SCALE_W-1:0] rep_q, rep_d;
	logic [SCALE_W-1:0] copy_q, copy_d;
	logic [1:0]         pad_q, pad_d;

	// effective limits
	logic [WIDTH_W-1:0] w;
	logic [SCALE_W-1:0] f;
	logic [1:0]         pads;

	// step logic
	logic               mode;
	logic               s_accept;
	logic               wr_en, rd_en;
	logic               end_line;
	status_t            res_status;
	logic               res_line_end, res_group_end;
	logic [WIDTH_W:0]   fill_inc;
	logic [WIDTH_W:0]   col_nx;
	logic [SCALE_W:0]   rep_inc;
	logic [SCALE_W:0]   copy_inc;
	logic [2:0]         pad_inc;
	logic [3:0]         pads_prod;

	// pipeline
	logic               valid_s1, valid_s2;
	status_t            status_s1, status_s2;
	logic               line_end_s1, line_end_s2;
	logic               group_end_s1, group_end_s2;
	pixel_t             rd_data_s1;
	pixel_t             pix_s2;
	logic               s2_free, adv2;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_factor_q <= SCALE_W'(1);
			source_width_q <= WIDTH_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCALE_FACTOR: scale_factor_q <= cfg_data[SCALE_W-1:0];
				CFG_SOURCE_WIDTH: source_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp registers to their usable ranges
	always_comb begin
		if (source_width_q == '0) begin
			w = WIDTH_W'(1);
		end else if ({6'b0, source_width_q} > MAX_W) begin
			w = WIDTH_W'(MAX_W);
		end else begin
			w = source_width_q;
		end
		if (scale_factor_q == '0) begin
			f = SCALE_W'(1);
		end else if ({1'b0, scale_factor_q} > MAX_F) begin
			f = SCALE_W'(MAX_F);
		end else begin
			f = scale_factor_q;
		end
	end

	// pad bytes per line: (width * factor) mod 4, from the low bits only
	assign pads_prod = w[1:0] * f[1:0];
	assign pads      = pads_prod[1:0];

	// handshake
	assign s2_free       = !valid_s2 || m_axis_tready;
	assign adv2          = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign mode          = s_axis_tuser[0];

	// next state and result for one beat
	always_comb begin
		fill_d        = fill_q;
		emit_d        = emit_q;
		col_d         = col_q;
		rep_d         = rep_q;
		copy_d        = copy_q;
		pad_d         = pad_q;
		res_status    = ST_STORED;
		res_line_end  = 1'b0;
		res_group_end = 1'b0;
		end_line      = 1'b0;
		wr_en         = 1'b0;
		rd_en         = 1'b0;
		fill_inc      = {1'b0, fill_q} + 1'b1;
		col_nx        = {1'b0, col_q};
		rep_inc       = {1'b0, rep_q} + 1'b1;
		copy_inc      = {1'b0, copy_q} + 1'b1;
		pad_inc       = {1'b0, pad_q} + 1'b1;

		if (mode != emit_q) begin
			res_status = ST_REJECT;
		end else if (!mode) begin
			// store a pixel, switch to emitting once the line is full
			wr_en  = ({1'b0, fill_q} < DEPTH_L);
			fill_d = fill_inc[WIDTH_W-1:0];
			if (fill_inc >= {1'b0, w}) begin
				fill_d = '0;
				emit_d = 1'b1;
				col_d  = '0;
				rep_d  = '0;
				copy_d = '0;
				pad_d  = '0;
			end
		end else if (col_q < w) begin
			// repeat the current source pixel
			res_status = ST_PIXEL;
			rd_en      = 1'b1;
			if (rep_inc >= {1'b0, f}) begin
				rep_d  = '0;
				col_nx = {1'b0, col_q} + 1'b1;
			end else begin
				rep_d = rep_inc[SCALE_W-1:0];
			end
			col_d = col_nx[WIDTH_W-1:0];
			if (col_nx >= {1'b0, w} && pads == '0) begin
				end_line = 1'b1;
			end
		end else begin
			// pad out the line
			res_status = ST_PAD;
			pad_d      = pad_inc[1:0];
			if (pad_inc >= {1'b0, pads}) begin
				end_line = 1'b1;
			end
		end

		// line done, maybe the whole group
		if (end_line) begin
			res_line_end = 1'b1;
			col_d        = '0;
			rep_d        = '0;
			pad_d        = '0;
			copy_d       = copy_inc[SCALE_W-1:0];
			if (copy_inc >= {1'b0, f}) begin
				res_group_end = 1'b1;
				copy_d        = '0;
				emit_d        = 1'b0;
				fill_d        = '0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			emit_q <= 1'b0;
			col_q  <= '0;
			rep_q  <= '0;
			copy_q <= '0;
			pad_q  <= '0;
		end else if (s_accept) begin
			fill_q <= fill_d;
			emit_q <= emit_d;
			col_q  <= col_d;
			rep_q  <= rep_d;
			copy_q <= copy_d;
			pad_q  <= pad_d;
		end
	end

	// line buffer
	nnlu_line_buf #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line_buf (
		.clk        (clk),
		.wr_en      (s_accept && wr_en),
		.wr_addr    (fill_q[AW-1:0]),
		.wr_data    (pixel_t'(s_axis_tdata)),
		.rd_en      (s_accept && rd_en),
		.rd_addr    (col_q[AW-1:0]),
		.rd_data_s1 (rd_data_s1)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv2) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			status_s1    <= res_status;
			line_end_s1  <= res_line_end;
			group_end_s1 <= res_group_end;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// output register payload, pixel bytes zero unless a pixel beat
	always_ff @(posedge clk) begin
		if (adv2) begin
			status_s2    <= status_s1;
			line_end_s2  <= line_end_s1;
			group_end_s2 <= group_end_s1;
			pix_s2       <= (status_s1 == ST_PIXEL) ? rd_data_s1 : '0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = pix_s2;
	assign m_axis_tlast  = line_end_s2;
	assign m_axis_tuser  = {group_end_s2, status_s2};

endmodule

/* sv/nnlu_line_buf.sv */
module nnlu_line_buf
	import nnlu_pkg::*;
#(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  pixel_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output pixel_t        rd_data_s1
);

	pixel_t mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule
